// ===== design/sample_ring_buffer_with_range_top_assert.svh =====
// Assertion macros for the sample ring buffer top level.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef SAMPLE_RING_BUFFER_WITH_RANGE_TOP_ASSERT_SVH
`define SAMPLE_RING_BUFFER_WITH_RANGE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// cons must hold in the cycle after ante
`define SRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
// cons must hold in the same cycle as ante
`define SRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define SRB_ASSERT_NEXT(lbl, ante, cons, msg)
`define SRB_ASSERT_NOW(lbl, ante, cons, msg)
`endif

`endif

// ===== design/srb_pkg.sv =====
// Shared types and constants for the sample ring buffer.
// Mode codes, field widths, controller/datapath command and status structs.
`default_nettype none

package srb_pkg;

  localparam int SAMPLE_W = 32;
  localparam int INDEX_W  = 10;
  localparam int FILL_W   = 11;
  localparam int HEAD_W   = 10;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 120;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  typedef struct packed {
    logic take;     // input word accepted this cycle
    logic scan_rd;  // issue one rescan read
    logic commit;   // write rescan result into the cache
    logic load;     // load the output register
  } srb_cmd_t;

  typedef struct packed {
    logic stale;     // cached range needs a rescan
    logic scan_last; // scan address is at the last slot
    logic out_free;  // output register can take a word
  } srb_status_t;

endpackage

`default_nettype wire

// ===== design/sample_ring_buffer_with_range_top.sv =====
// Sample ring buffer with min/max range cache: top level, srb_ctrl + srb_dp.
// Push, clear, read and cached range query; each result is loaded into the
// free output register before the next word is accepted. A stale range query
// rescans all DEPTH slots through the single memory read port. Synchronous
// active-low reset empties the buffer at once, with no memory clearing pass.
`default_nettype none

`include "sample_ring_buffer_with_range_top_assert.svh"

module sample_ring_buffer_with_range_top import srb_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [1:0] mode, [33:2] sample, [43:34] read_index, [47:44] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tlast,   // burst_last, no effect
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [31:0] read_value, [63:32] range_min, [95:64] range_max,
  // [106:96] fill_count, [116:107] head_position, [119:117] zero
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  srb_cmd_t    cmd;
  srb_status_t status;

  logic [1:0]          in_mode;
  logic [SAMPLE_W-1:0] in_sample;
  logic [INDEX_W-1:0]  in_read_index;

  assign in_mode       = in_tdata[1:0];
  assign in_sample     = in_tdata[33:2];
  assign in_read_index = in_tdata[43:34];

  srb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_mode  (in_mode),
    .status   (status),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  srb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_mode       (in_mode),
    .in_sample     (in_sample),
    .in_read_index (in_read_index),
    .out_ready     (out_tready),
    .status        (status),
    .out_valid     (out_tvalid),
    .out_data      (out_tdata)
  );

  `SRB_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accepted back to back")
  `SRB_ASSERT_NOW(a_range_order, out_tvalid, $signed(out_tdata[63:32]) <= $signed(out_tdata[95:64]), "range_min above range_max")
  `SRB_ASSERT_NOW(a_read_no_range, out_tvalid && out_tdata[31:0] != 32'd0, out_tdata[95:32] == 64'd0, "read word carries range")
  `SRB_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output word changed while stalled")

endmodule

`default_nettype wire

// ===== design/srb_ctrl.sv =====
// Controller FSM for the sample ring buffer.
// Depends on srb_pkg; drives srb_dp through srb_cmd_t.
`default_nettype none

module srb_ctrl import srb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [1:0]  in_mode,
  input  wire srb_status_t status,
  output logic             in_ready,
  output srb_cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_mode == MODE_QUERY && status.stale) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read data lands here
        cmd.commit = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/srb_dp.sv =====
// Datapath for the sample ring buffer: sample memory, head/wrap state,
// range scan and cache, output register. Depends on srb_pkg.
`default_nettype none

module srb_dp import srb_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire srb_cmd_t              cmd,
  input  wire logic [1:0]            in_mode,
  input  wire logic [SAMPLE_W-1:0]   in_sample,
  input  wire logic [INDEX_W-1:0]    in_read_index,
  input  wire logic                  out_ready,
  output srb_status_t                status,
  output logic                       out_valid,
  output logic [OUT_DATA_W-1:0]      out_data
);

  localparam int HW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int SW = ((HW > INDEX_W) ? HW : INDEX_W) + 1;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  logic [HW-1:0] head_r;
  logic          wrapped_r;
  logic          empty_r;
  logic          stale_r;
  logic signed [SAMPLE_W-1:0] cache_min_r, cache_max_r;

  logic [1:0]          mode_r;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                rd_ok_r;

  logic [HW-1:0] scan_addr_r;
  logic          scan_vld_r;
  logic          scan_first_r;
  logic          scan_live_r;
  logic signed [SAMPLE_W-1:0] acc_lo_r, acc_hi_r, acc_lo_nxt, acc_hi_nxt;

  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // logical to physical index
  logic [SW-1:0] idx_x, head_x, sum_x, phys_x;
  logic          idx_ok, phys_written;

  always_comb begin
    idx_x  = SW'(in_read_index);
    head_x = SW'(head_r);
    sum_x  = head_x + idx_x;
    if (wrapped_r) begin
      phys_x = (sum_x >= SW'(DEPTH)) ? sum_x - SW'(DEPTH) : sum_x;
    end else begin
      phys_x = idx_x;
    end
    idx_ok       = idx_x < SW'(DEPTH);
    // slots at or past the head were never written since the last clear
    phys_written = wrapped_r || (phys_x < head_x);
  end

  logic          push_en, rd_en;
  logic [HW-1:0] rd_addr;

  assign push_en = cmd.take && (in_mode == MODE_PUSH);
  assign rd_en   = (cmd.take && (in_mode == MODE_READ)) || cmd.scan_rd;
  assign rd_addr = cmd.scan_rd ? scan_addr_r : phys_x[HW-1:0];

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[head_r] <= in_sample;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // buffer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      wrapped_r   <= 1'b0;
      empty_r     <= 1'b1;
      stale_r     <= 1'b1;
      cache_min_r <= '0;
      cache_max_r <= '0;
    end else if (cmd.take && in_mode == MODE_PUSH) begin
      if (head_r == HW'(DEPTH - 1)) begin
        head_r    <= '0;
        wrapped_r <= 1'b1;
      end else begin
        head_r <= head_r + HW'(1);
      end
      stale_r <= 1'b1;
      empty_r <= 1'b0;
    end else if (cmd.take && in_mode == MODE_CLEAR) begin
      head_r      <= '0;
      wrapped_r   <= 1'b0;
      empty_r     <= 1'b1;
      stale_r     <= 1'b0;
      cache_min_r <= '0;
      cache_max_r <= '0;
    end else if (cmd.commit) begin
      cache_min_r <= acc_lo_nxt;
      cache_max_r <= acc_hi_nxt;
      stale_r     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mode_r  <= in_mode;
      rd_ok_r <= idx_ok && phys_written;
    end
  end

  // rescan: one read per cycle, compare in the following cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_vld_r <= 1'b0;
    end else begin
      scan_vld_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      scan_addr_r <= '0;
    end else if (cmd.scan_rd) begin
      scan_addr_r <= scan_addr_r + HW'(1);
    end
    scan_first_r <= scan_addr_r == '0;
    scan_live_r  <= wrapped_r || (scan_addr_r < head_r);
    acc_lo_r     <= acc_lo_nxt;
    acc_hi_r     <= acc_hi_nxt;
  end

  logic signed [SAMPLE_W-1:0] scan_val;

  always_comb begin
    scan_val   = scan_live_r ? $signed(rd_data_r) : '0;
    acc_lo_nxt = acc_lo_r;
    acc_hi_nxt = acc_hi_r;
    if (scan_vld_r) begin
      if (scan_first_r) begin
        acc_lo_nxt = scan_val;
        acc_hi_nxt = scan_val;
      end else begin
        if (scan_val < acc_lo_r) acc_lo_nxt = scan_val;
        if (scan_val > acc_hi_r) acc_hi_nxt = scan_val;
      end
    end
  end

  // result fields
  logic [FW-1:0]       fill;
  logic [31:0]         fill_ext, head_ext;
  logic [SAMPLE_W-1:0] res_value, res_min, res_max;

  always_comb begin
    if (wrapped_r) begin
      fill = FW'(DEPTH);
    end else if (empty_r) begin
      fill = '0;
    end else begin
      fill = FW'(head_r);
    end
    fill_ext  = 32'(fill);
    head_ext  = 32'(head_r);
    res_value = (mode_r == MODE_READ && rd_ok_r) ? rd_data_r : '0;
    res_min   = (mode_r == MODE_QUERY) ? cache_min_r : '0;
    res_max   = (mode_r == MODE_QUERY) ? cache_max_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= {3'b000, head_ext[HEAD_W-1:0], fill_ext[FILL_W-1:0],
                     res_max, res_min, res_value};
    end
  end

  assign status.stale     = stale_r;
  assign status.scan_last = scan_addr_r == HW'(DEPTH - 1);
  assign status.out_free  = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;

endmodule

`default_nettype wire
